// ===== hdl/gmdc_pkg.sv =====
// Shared types and constants of the grid maze carver.
package gmdc_pkg;

  // Fixed field widths of the ports.
  localparam int CFG_W   = 7;
  localparam int CELL_W  = 6;
  localparam int RND_W   = 16;
  localparam int KIND_W  = 2;
  localparam int DIR_W   = 2;
  localparam int INDEX_W = 2;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    EV_STARTED     = 2'd0,
    EV_CARVED      = 2'd1,
    EV_BACKTRACKED = 2'd2,
    EV_FINISHED    = 2'd3
  } ev_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  typedef enum logic [INDEX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_START_X     = 2'd2,
    REG_START_Y     = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_START_WR,
    ST_SCAN,
    ST_PICK,
    ST_POP_RD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clr_step;
    logic start_wr;
    logic scan_step;
    logic pick;
    logic pop_load;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stack_empty;
    logic sweep_last;
    logic scan_last;
    logic pop_refill;
  } sts_t;

endpackage

// ===== hdl/gmdc_ram.sv =====
// Generic simple dual-port RAM with registered read.
module gmdc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/gmdc_ctrl.sv =====
// Controller state machine of the grid maze carver.
module gmdc_ctrl import gmdc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic in_op,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_op == OP_START) begin
            state_nxt = ST_CLEAR;
          end else if (!sts.stack_empty) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_CLEAR: begin
        if (sts.sweep_last) begin
          state_nxt = ST_START_WR;
        end
      end
      ST_START_WR: state_nxt = ST_IDLE;
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: state_nxt = sts.pop_refill ? ST_POP_RD : ST_IDLE;
      ST_POP_RD: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_op == OP_START || !sts.stack_empty) begin
            cmd.load = 1'b1;
          end else begin
            cmd.finish = 1'b1;
          end
        end
      end
      ST_CLEAR:    cmd.clr_step  = 1'b1;
      ST_START_WR: cmd.start_wr  = 1'b1;
      ST_SCAN:     cmd.scan_step = 1'b1;
      ST_PICK:     cmd.pick      = 1'b1;
      ST_POP_RD:   cmd.pop_load  = 1'b1;
      default:     cmd = '0;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== hdl/gmdc_datapath.sv =====
// Datapath of the grid maze carver: stack, visited map, walls and result registers.
module gmdc_datapath import gmdc_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [RND_W-1:0]  in_random_value,
  input  logic [CFG_W-1:0]  cfg_grid_width,
  input  logic [CFG_W-1:0]  cfg_grid_height,
  input  logic [CELL_W-1:0] cfg_start_x,
  input  logic [CELL_W-1:0] cfg_start_y,
  output logic              out_valid,
  output logic [KIND_W-1:0] out_event_kind,
  output logic [CELL_W-1:0] out_cell_x,
  output logic [CELL_W-1:0] out_cell_y,
  output logic [DIR_W-1:0]  out_move_direction
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int VW    = XW + YW;
  localparam int VDEP  = 2 ** VW;
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int SAW   = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int EW    = (WW > CFG_W) ? WW : CFG_W;
  localparam int EH    = (HW > CFG_W) ? HW : CFG_W;

  // Residue mod 3 of a five-bit sum by folding base-4 digits.
  function automatic logic [1:0] mod3_fold(input logic [4:0] v);
    logic [3:0] f;
    logic [2:0] g;
    f = 4'(v[4:2]) + 4'(v[1:0]);
    g = 3'(f[3:2]) + 3'(f[1:0]);
    return (g >= 3'd3) ? 2'(g - 3'd3) : g[1:0];
  endfunction

  logic [RND_W-1:0] rnd_r;
  logic [XW-1:0]    sx_r, top_x_r;
  logic [YW-1:0]    sy_r, top_y_r;
  logic [CW-1:0]    count_r;
  logic [1:0]       scan_r;
  logic [2:0]       vis_r;
  logic [1:0]       r3_r;
  logic [VW-1:0]    sweep_r;
  logic             out_valid_r;
  ev_t              out_kind_r;
  logic [CELL_W-1:0] out_x_r, out_y_r;
  dir_t             out_dir_r;

  logic [EW-1:0] eff_w, sx_ext, sx_sat, xe;
  logic [EH-1:0] eff_h, sy_ext, sy_sat, ye;
  logic [EW-1:0] nb_x [4];
  logic [EH-1:0] nb_y [4];
  logic [3:0]    in_grid, free;
  logic [2:0]    free_cnt;
  logic [1:0]    k_sel, seen;
  dir_t          sel_dir;
  logic          found, carve;
  logic [XW-1:0] new_x;
  logic [YW-1:0] new_y;

  logic          vis_we, vis_wdata, vis_rd;
  logic [VW-1:0] vis_waddr, vis_raddr;
  logic          bot_we, bot_wdata, rgt_we, rgt_wdata;
  logic [VW-1:0] bot_waddr, rgt_waddr;
  logic          stk_we;
  logic [SAW-1:0] stk_waddr, stk_raddr;
  logic [VW-1:0] stk_wdata, stk_rd;
  logic [4:0]    r3_sum;

  // Clamp the configured size into the legal range and saturate the start cell into it.
  always_comb begin
    sx_ext = EW'(cfg_start_x);
    sy_ext = EH'(cfg_start_y);
    if (cfg_grid_width == '0) begin
      eff_w = EW'(1);
    end else if (EW'(cfg_grid_width) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(cfg_grid_width);
    end
    if (cfg_grid_height == '0) begin
      eff_h = EH'(1);
    end else if (EH'(cfg_grid_height) > EH'(MAX_HEIGHT)) begin
      eff_h = EH'(MAX_HEIGHT);
    end else begin
      eff_h = EH'(cfg_grid_height);
    end
    sx_sat = (sx_ext < eff_w) ? sx_ext : eff_w - EW'(1);
    sy_sat = (sy_ext < eff_h) ? sy_ext : eff_h - EH'(1);
  end

  // Neighbour coordinates and grid membership for all four directions.
  always_comb begin
    xe = EW'(top_x_r);
    ye = EH'(top_y_r);
    for (int d = 0; d < 4; d++) begin
      nb_x[d]    = xe;
      nb_y[d]    = ye;
      in_grid[d] = 1'b0;
      unique case (dir_t'(d))
        DIR_UP: begin
          nb_y[d]    = ye - EH'(1);
          in_grid[d] = (ye != '0) && (xe < eff_w) && (ye - EH'(1) < eff_h);
        end
        DIR_RIGHT: begin
          nb_x[d]    = xe + EW'(1);
          in_grid[d] = (xe + EW'(1) < eff_w) && (ye < eff_h);
        end
        DIR_DOWN: begin
          nb_y[d]    = ye + EH'(1);
          in_grid[d] = (xe < eff_w) && (ye + EH'(1) < eff_h);
        end
        DIR_LEFT: begin
          nb_x[d]    = xe - EW'(1);
          in_grid[d] = (xe != '0) && (xe - EW'(1) < eff_w) && (ye < eff_h);
        end
        default: in_grid[d] = 1'b0;
      endcase
    end
  end

  // Choose among the free neighbours; the last visited bit comes straight from the RAM.
  always_comb begin
    free     = in_grid & ~{vis_rd, vis_r};
    free_cnt = 3'($countones(free));
    unique case (free_cnt)
      3'd2:    k_sel = {1'b0, rnd_r[0]};
      3'd3:    k_sel = r3_r;
      3'd4:    k_sel = rnd_r[1:0];
      default: k_sel = 2'd0;
    endcase
    sel_dir = DIR_UP;
    found   = 1'b0;
    seen    = 2'd0;
    for (int d = 0; d < 4; d++) begin
      if (free[d] && !found) begin
        if (seen == k_sel) begin
          sel_dir = dir_t'(d);
          found   = 1'b1;
        end
        seen = seen + 2'd1;
      end
    end
    carve = (free_cnt != 3'd0) && (count_r < CW'(CELLS));
    new_x = XW'(nb_x[sel_dir]);
    new_y = YW'(nb_y[sel_dir]);
  end

  assign r3_sum = 5'(r3_r) + 5'(rnd_r[{scan_r, 2'b00} +: 4]);

  // Memory port steering.
  always_comb begin
    vis_we    = 1'b0;
    vis_wdata = 1'b1;
    vis_waddr = {new_y, new_x};
    bot_we    = 1'b0;
    bot_wdata = 1'b0;
    bot_waddr = {new_y, new_x};
    rgt_we    = 1'b0;
    rgt_wdata = 1'b0;
    rgt_waddr = {new_y, new_x};
    stk_we    = 1'b0;
    stk_waddr = SAW'(count_r);
    stk_wdata = {new_y, new_x};
    priority if (cmd.clr_step) begin
      vis_we    = 1'b1;
      vis_wdata = 1'b0;
      vis_waddr = sweep_r;
      bot_we    = 1'b1;
      bot_wdata = 1'b1;
      bot_waddr = sweep_r;
      rgt_we    = 1'b1;
      rgt_wdata = 1'b1;
      rgt_waddr = sweep_r;
    end else if (cmd.start_wr) begin
      vis_we    = 1'b1;
      vis_waddr = {sy_r, sx_r};
      stk_we    = 1'b1;
      stk_waddr = '0;
      stk_wdata = {sy_r, sx_r};
    end else if (cmd.pick && carve) begin
      vis_we = 1'b1;
      stk_we = 1'b1;
      unique case (sel_dir)
        DIR_UP:    bot_we = 1'b1;
        DIR_RIGHT: begin
          rgt_we    = 1'b1;
          rgt_waddr = {top_y_r, top_x_r};
        end
        DIR_DOWN:  begin
          bot_we    = 1'b1;
          bot_waddr = {top_y_r, top_x_r};
        end
        DIR_LEFT:  rgt_we = 1'b1;
        default:   bot_we = 1'b0;
      endcase
    end
  end

  assign vis_raddr = {YW'(nb_y[scan_r]), XW'(nb_x[scan_r])};
  assign stk_raddr = SAW'(count_r - CW'(2));

  gmdc_ram #(.WIDTH(1), .DEPTH(VDEP)) u_visited (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (vis_raddr),
    .rdata (vis_rd)
  );

  gmdc_ram #(.WIDTH(1), .DEPTH(VDEP)) u_bottom_walls (
    .clk   (clk),
    .we    (bot_we),
    .waddr (bot_waddr),
    .wdata (bot_wdata),
    .raddr ('0),
    .rdata ()
  );

  gmdc_ram #(.WIDTH(1), .DEPTH(VDEP)) u_right_walls (
    .clk   (clk),
    .we    (rgt_we),
    .waddr (rgt_waddr),
    .wdata (rgt_wdata),
    .raddr ('0),
    .rdata ()
  );

  gmdc_ram #(.WIDTH(VW), .DEPTH(CELLS)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rd)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      scan_r      <= '0;
      sweep_r     <= '0;
    end else begin
      out_valid_r <= cmd.start_wr | cmd.pick | cmd.finish;
      if (cmd.load) begin
        scan_r  <= '0;
        sweep_r <= '0;
      end
      if (cmd.clr_step) begin
        sweep_r <= sweep_r + VW'(1);
      end
      if (cmd.scan_step) begin
        scan_r <= scan_r + 2'd1;
      end
      if (cmd.start_wr) begin
        count_r <= CW'(1);
      end else if (cmd.pick) begin
        count_r <= carve ? count_r + CW'(1) : count_r - CW'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rnd_r <= in_random_value;
      sx_r  <= XW'(sx_sat);
      sy_r  <= YW'(sy_sat);
      r3_r  <= 2'd0;
    end
    if (cmd.scan_step) begin
      r3_r <= mod3_fold(r3_sum);
      if (scan_r != 2'd0) begin
        vis_r[scan_r - 2'd1] <= vis_rd;
      end
    end
    if (cmd.start_wr) begin
      top_x_r <= sx_r;
      top_y_r <= sy_r;
    end else if (cmd.pick && carve) begin
      top_x_r <= new_x;
      top_y_r <= new_y;
    end else if (cmd.pop_load) begin
      top_x_r <= stk_rd[XW-1:0];
      top_y_r <= stk_rd[VW-1:XW];
    end
    priority if (cmd.start_wr) begin
      out_kind_r <= EV_STARTED;
      out_x_r    <= CELL_W'(sx_r);
      out_y_r    <= CELL_W'(sy_r);
      out_dir_r  <= DIR_UP;
    end else if (cmd.pick && carve) begin
      out_kind_r <= EV_CARVED;
      out_x_r    <= CELL_W'(new_x);
      out_y_r    <= CELL_W'(new_y);
      out_dir_r  <= sel_dir;
    end else if (cmd.pick) begin
      out_kind_r <= EV_BACKTRACKED;
      out_x_r    <= CELL_W'(top_x_r);
      out_y_r    <= CELL_W'(top_y_r);
      out_dir_r  <= DIR_UP;
    end else if (cmd.finish) begin
      out_kind_r <= EV_FINISHED;
      out_x_r    <= '0;
      out_y_r    <= '0;
      out_dir_r  <= DIR_UP;
    end
  end

  always_comb begin
    sts.stack_empty = (count_r == '0);
    sts.sweep_last  = &sweep_r;
    sts.scan_last   = (scan_r == 2'd3);
    sts.pop_refill  = !carve && (count_r >= CW'(2));
  end

  assign out_valid          = out_valid_r;
  assign out_event_kind     = out_kind_r;
  assign out_cell_x         = out_x_r;
  assign out_cell_y         = out_y_r;
  assign out_move_direction = out_dir_r;

endmodule

// ===== hdl/grid_maze_dfs_carver.sv =====
// Top level of the grid maze carver: configuration registers, controller and datapath.
//
// Carves a maze by randomised depth-first search with an explicit cell stack.
// Issue a command beat by raising start while busy is low; in_op selects a new
// maze or one search step, in_random_value chooses among the free neighbours.
// Every command returns exactly one result beat on the out_ ports, marked by
// out_valid for one cycle; the receiver cannot stall, so take it when it shows.
// A start command runs a clearing sweep over the visited map and both wall maps,
// one entry a cycle, with busy high, and the started beat follows. A step holds
// busy over four visited-map reads through the single read port, one per
// neighbour, and then the decision; a backtrack that leaves cells on the stack
// also holds busy while it reloads the new top from the stack RAM. The step's
// beat shows in the cycle after the decision. A step on an empty stack
// returns the finished beat in the next cycle without raising busy.
// Write configuration only while the block is idle.
module grid_maze_dfs_carver import gmdc_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic [RND_W-1:0]   in_random_value,
  output logic               out_valid,
  output logic [KIND_W-1:0]  out_event_kind,
  output logic [CELL_W-1:0]  out_cell_x,
  output logic [CELL_W-1:0]  out_cell_y,
  output logic [DIR_W-1:0]   out_move_direction,
  input  logic               cfg_we,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  logic [CFG_W-1:0]  grid_width_r, grid_height_r;
  logic [CELL_W-1:0] start_x_r, start_y_r;
  cmd_t              cmd;
  sts_t              sts;

  // Configuration registers: take a write beat whenever the enable is high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= CFG_W'(16);
      grid_height_r <= CFG_W'(16);
      start_x_r     <= '0;
      start_y_r     <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        REG_GRID_HEIGHT: grid_height_r <= cfg_data;
        REG_START_X:     start_x_r     <= cfg_data[CELL_W-1:0];
        REG_START_Y:     start_y_r     <= cfg_data[CELL_W-1:0];
        default:         grid_width_r  <= grid_width_r;
      endcase
    end
  end

  // Sequence the sweep, neighbour scan, decision and stack reload.
  gmdc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold the stack, the maps and the result registers.
  gmdc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_random_value    (in_random_value),
    .cfg_grid_width     (grid_width_r),
    .cfg_grid_height    (grid_height_r),
    .cfg_start_x        (start_x_r),
    .cfg_start_y        (start_y_r),
    .out_valid          (out_valid),
    .out_event_kind     (out_event_kind),
    .out_cell_x         (out_cell_x),
    .out_cell_y         (out_cell_y),
    .out_move_direction (out_move_direction)
  );

  // A new maze always enters the clearing sweep.
  a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_op == OP_START) |=> busy)
    else $error("start command did not raise busy");

  // A result beat only follows an accepted command or work in progress.
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) || $past(start))
    else $error("result beat without a command");

  // The finished beat carries no cell and no direction.
  a_finished_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_FINISHED) |->
      (out_cell_x == '0) && (out_cell_y == '0) && (out_move_direction == DIR_UP))
    else $error("finished beat with non-zero payload");

endmodule

// ===== verif/tb_grid_maze_dfs_carver.sv =====
// Self-checking bench for the grid maze carver: predicts and checks every result beat.
module tb_grid_maze_dfs_carver;
  import gmdc_pkg::*;

  localparam int MAX_W      = 64;
  localparam int MAX_H      = 64;
  localparam int CELLS      = MAX_W * MAX_H;
  localparam int LIMIT      = 20_000_000;  // cycles before the run is called hung
  localparam int RAND_ITEMS = 850;
  localparam int PRINT_CAP  = 60;          // mismatch lines printed before going quiet

  // One result beat as the block presents it.
  typedef struct packed {
    ev_t               kind;
    logic [CELL_W-1:0] x;
    logic [CELL_W-1:0] y;
    dir_t              dir;
  } maze_beat_t;

  // Scoreboard: mirrors the carver's map and stack, queues predicted beats and
  // compares them with what comes out.
  class maze_scoreboard;
    int unsigned grid_w, grid_h, first_x, first_y;
    bit          visited [CELLS];
    int unsigned path_stack [CELLS];
    int unsigned path_depth;
    maze_beat_t  pending_beats [$];
    int unsigned errors;
    int unsigned beats_seen [4];

    function new();
      grid_w     = 16;
      grid_h     = 16;
      first_x    = 0;
      first_y    = 0;
      path_depth = 0;
      errors     = 0;
      foreach (beats_seen[i]) beats_seen[i] = 0;
    endfunction

    function int unsigned outstanding();
      return pending_beats.size();
    endfunction

    function void write_reg(reg_index_t idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_GRID_WIDTH:  grid_w  = data;
        REG_GRID_HEIGHT: grid_h  = data;
        REG_START_X:     first_x = data[CELL_W-1:0];
        REG_START_Y:     first_y = data[CELL_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the mirrored maze by one accepted command and queue its beat.
    function void note_command(op_t op, logic [RND_W-1:0] rnd);
      int unsigned w, h, sx, sy, top, x, y, nx, ny, cnt, k;
      bit          ok;
      dir_t        cand_dir [4];
      int unsigned cand_x [4];
      int unsigned cand_y [4];
      maze_beat_t  b;
      w = (grid_w == 0) ? 1 : ((grid_w > MAX_W) ? MAX_W : grid_w);
      h = (grid_h == 0) ? 1 : ((grid_h > MAX_H) ? MAX_H : grid_h);
      if (op == OP_START) begin
        // Saturate the start cell into the grid, wipe the map, seed the stack.
        sx = (first_x < w) ? first_x : w - 1;
        sy = (first_y < h) ? first_y : h - 1;
        foreach (visited[i]) visited[i] = 1'b0;
        path_stack[0] = sy * MAX_W + sx;
        path_depth    = 1;
        visited[sy * MAX_W + sx] = 1'b1;
        b = '{kind: EV_STARTED, x: CELL_W'(sx), y: CELL_W'(sy), dir: DIR_UP};
      end else if (path_depth == 0) begin
        b = '{kind: EV_FINISHED, x: '0, y: '0, dir: DIR_UP};
      end else begin
        top = path_stack[path_depth - 1];
        x   = top % MAX_W;
        y   = top / MAX_W;
        cnt = 0;
        // List free neighbours up, right, down, left; only cells inside the
        // current grid count, even when the top itself lies outside it.
        for (int d = 0; d < 4; d++) begin
          nx = x;
          ny = y;
          ok = 1'b1;
          case (dir_t'(d))
            DIR_UP:    if (y == 0) ok = 1'b0; else ny = y - 1;
            DIR_RIGHT: nx = x + 1;
            DIR_DOWN:  ny = y + 1;
            default:   if (x == 0) ok = 1'b0; else nx = x - 1;
          endcase
          if (ok && nx < w && ny < h && !visited[ny * MAX_W + nx]) begin
            cand_dir[cnt] = dir_t'(d);
            cand_x[cnt]   = nx;
            cand_y[cnt]   = ny;
            cnt++;
          end
        end
        if (cnt > 0 && path_depth < CELLS) begin
          k = rnd % cnt;
          visited[cand_y[k] * MAX_W + cand_x[k]] = 1'b1;
          path_stack[path_depth] = cand_y[k] * MAX_W + cand_x[k];
          path_depth++;
          b = '{kind: EV_CARVED, x: CELL_W'(cand_x[k]), y: CELL_W'(cand_y[k]),
                dir: cand_dir[k]};
        end else begin
          path_depth--;
          b = '{kind: EV_BACKTRACKED, x: CELL_W'(x), y: CELL_W'(y), dir: DIR_UP};
        end
      end
      pending_beats.push_back(b);
    endfunction

    task report(string what);
      errors++;
      if (errors <= PRINT_CAP) $display("[%0t] beat check failed: %s", $time, what);
    endtask

    task check_beat(maze_beat_t got);
      maze_beat_t want;
      if (pending_beats.size() == 0) begin
        report("result beat with no command outstanding");
        return;
      end
      want = pending_beats.pop_front();
      beats_seen[want.kind]++;
      if (got.kind !== want.kind)
        report($sformatf("event kind %0d, predicted %0d", got.kind, want.kind));
      if (got.x !== want.x)
        report($sformatf("cell_x %0d, predicted %0d", got.x, want.x));
      if (got.y !== want.y)
        report($sformatf("cell_y %0d, predicted %0d", got.y, want.y));
      if (got.dir !== want.dir)
        report($sformatf("move direction %0d, predicted %0d", got.dir, want.dir));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_op;
  logic [RND_W-1:0]   in_random_value;
  logic               out_valid;
  logic [KIND_W-1:0]  out_event_kind;
  logic [CELL_W-1:0]  out_cell_x;
  logic [CELL_W-1:0]  out_cell_y;
  logic [DIR_W-1:0]   out_move_direction;
  logic               cfg_we;
  logic [INDEX_W-1:0] cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  maze_scoreboard sb;
  int unsigned    idle_pct;
  int unsigned    items_sent;
  int unsigned    mazes;
  int unsigned    cycles;

  grid_maze_dfs_carver #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sample at the rising edge: take the result beat first, so that a command
  // accepted on the same edge never masks a stray result, then the command
  // beat and any register write.
  always @(posedge clk) begin : monitor
    maze_beat_t seen;
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1) begin
        seen = '{kind: ev_t'(out_event_kind), x: out_cell_x, y: out_cell_y,
                 dir: dir_t'(out_move_direction)};
        sb.check_beat(seen);
      end
      if (start === 1'b1 && busy === 1'b0) sb.note_command(op_t'(in_op), in_random_value);
      if (cfg_we === 1'b1) sb.write_reg(reg_index_t'(cfg_index), cfg_data);
    end
    cycles++;
    if (cycles > LIMIT) begin
      $display("run hung after %0d cycles with %0d beats outstanding",
               cycles, sb.outstanding());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Drive one command beat. Entered just after a falling edge and left just
  // after the falling edge that follows acceptance, with start still high so
  // that back-to-back beats need no drop in between.
  task automatic send_item(op_t op, logic [RND_W-1:0] rnd);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start           <= 1'b1;
    in_op           <= op;
    in_random_value <= rnd;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop start and hold until every predicted beat has come and busy is low.
  task automatic settle();
    start <= 1'b0;
    while (sb.outstanding() != 0 || busy !== 1'b0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Reprogram all four registers once the block has gone quiet.
  task automatic configure(int unsigned w, int unsigned h, int unsigned sx, int unsigned sy);
    settle();
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
  endtask

  // Start a maze and step it until the stack empties or the cap is hit; at
  // step twist_at resize the grid under the live stack. Finish with a step or
  // two more, which report finished if the stack has emptied.
  task automatic run_maze(int unsigned w, int unsigned h, int unsigned sx, int unsigned sy,
                          int unsigned cap, int unsigned twist_at);
    int unsigned n;
    configure(w, h, sx, sy);
    send_item(OP_START, RND_W'($urandom));
    mazes++;
    n = 0;
    while (sb.path_depth != 0 && n < cap) begin
      if (n == twist_at)
        configure($urandom_range(1, 8), $urandom_range(1, 8), sx, sy);
      send_item(OP_STEP, RND_W'($urandom));
      n++;
    end
    repeat ($urandom_range(1, 2)) send_item(OP_STEP, RND_W'($urandom));
  endtask

  function automatic int unsigned clamp_size(int unsigned v, int unsigned max_v);
    return (v == 0) ? 1 : ((v > max_v) ? max_v : v);
  endfunction

  initial begin
    int unsigned r, w, h, sx, sy, cap, twist_at, directed;
    sb              = new();
    cycles          = 0;
    items_sent      = 0;
    mazes           = 0;
    idle_pct        = 17;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_op           = OP_START;
    in_random_value = '0;
    cfg_we          = 1'b0;
    cfg_index       = REG_GRID_WIDTH;
    cfg_data        = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Step on the empty stack left by reset, then a maze on the reset grid.
    send_item(OP_STEP, 16'hFFFF);
    send_item(OP_START, 16'h0000);
    send_item(OP_STEP, 16'h0000);
    send_item(OP_STEP, 16'hFFFF);
    send_item(OP_STEP, 16'h0001);
    send_item(OP_STEP, 16'h0002);

    // Zero size reads as one cell; an out-of-grid start saturates onto it.
    configure(0, 0, 127, 127);
    send_item(OP_START, 16'h5A5A);
    send_item(OP_STEP, 16'hFFFF);
    send_item(OP_STEP, 16'h0000);

    // Oversized grid clamps to the maximum; start in the far corner.
    configure(127, 127, 63, 63);
    send_item(OP_START, 16'hA5A5);
    send_item(OP_STEP, 16'hFFFF);
    send_item(OP_STEP, 16'h0000);
    send_item(OP_STEP, 16'h8001);

    // Full grid from the centre, then shrink it so the whole stack lies outside.
    configure(64, 64, 32, 32);
    send_item(OP_START, 16'h0000);
    send_item(OP_STEP, 16'h0003);
    send_item(OP_STEP, 16'h0001);
    send_item(OP_STEP, 16'h0002);
    configure(2, 2, 0, 0);
    repeat (5) send_item(OP_STEP, RND_W'($urandom));
    directed = items_sent;

    // Random mazes: mostly small grids walked to completion, with a share of
    // long thin ones, clamped sizes, resizes under a live stack and restarts.
    while (items_sent < directed + RAND_ITEMS) begin
      idle_pct = (mazes >= 6 && mazes < 12) ? 0 : 17;
      r        = $urandom_range(99);
      cap      = 400;
      twist_at = 32'hFFFF_FFFF;
      if (r < 68) begin
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 6);
      end else if (r < 76) begin
        w = $urandom_range(1) ? 64 : 1;
        h = (w == 64) ? 1 : 64;
      end else if (r < 84) begin
        w   = $urandom_range(1) ? 0 : $urandom_range(65, 127);
        h   = $urandom_range(0, 2);
        cap = 60;
      end else if (r < 90) begin
        w   = $urandom_range(64, 127);
        h   = $urandom_range(64, 127);
        cap = 40;
      end else begin
        w = $urandom_range(1, 10);
        h = $urandom_range(1, 10);
      end
      if ($urandom_range(9) == 0) begin
        sx = $urandom_range(127);
        sy = $urandom_range(127);
      end else begin
        sx = $urandom_range(0, 63) % clamp_size(w, MAX_W);
        sy = $urandom_range(0, 63) % clamp_size(h, MAX_H);
      end
      if ($urandom_range(99) < 12) twist_at = $urandom_range(1, 12);
      if ($urandom_range(99) < 8) cap = $urandom_range(0, 5);
      run_maze(w, h, sx, sy, cap, twist_at);
    end

    settle();
    repeat (16) @(negedge clk);
    $display("covered %0d command beats over %0d mazes in %0d cycles", items_sent,
             mazes + 4, cycles);
    $display("beats seen: %0d started, %0d carved, %0d backtracked, %0d finished",
             sb.beats_seen[EV_STARTED], sb.beats_seen[EV_CARVED],
             sb.beats_seen[EV_BACKTRACKED], sb.beats_seen[EV_FINISHED]);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/gmdc_pkg.sv
hdl/gmdc_ram.sv
hdl/gmdc_ctrl.sv
hdl/gmdc_datapath.sv
hdl/grid_maze_dfs_carver.sv
verif/tb_grid_maze_dfs_carver.sv
